### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk and disabled while arst_n
// is low. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must never hold.
`define TTW_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define TTW_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define TTW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define TTW_ASSERT_NEVER(label, expr)
`define TTW_ASSERT_IMPL(label, ante, cons)
`define TTW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/ttw_pkg.sv
// ----------------------------------------------------------------------------
// Text terminal writer package
// Field widths, request codes, character codes and the result record shared
// by the console engine, its channels and its sequencer.
// ----------------------------------------------------------------------------
package ttw_pkg;

	// Default screen geometry
	localparam int SCREEN_COLUMNS_DEF = 80;
	localparam int SCREEN_ROWS_DEF    = 25;

	// Field widths of the channels
	localparam int REQ_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int INDEX_W   = 11;
	localparam int COL_OUT_W = 7;
	localparam int ROW_OUT_W = 5;
	localparam int POS_OUT_W = 11;
	localparam int ATTR_W    = 8;
	localparam int CELL_W    = 16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Character codes with a meaning of their own
	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] BLANK_GLYPH    = 8'h20;

	// Attribute after reset: light grey on black
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	// One result record, as handed from the sequencer to the output register
	typedef struct packed {
		logic [COL_OUT_W-1:0] cursor_column;
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [POS_OUT_W-1:0] cursor_position;
		logic                 did_scroll;
		logic [CELL_W-1:0]    cell_value;
	} result_t;

endpackage

### rtl/ttw_channels.sv
// ----------------------------------------------------------------------------
// Text terminal writer channels
// Valid/ready channel bundles for requests, results and the attribute write.
// ----------------------------------------------------------------------------

// Request channel
interface ttw_req_if;
	import ttw_pkg::*;

	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [CHAR_W-1:0]  char_code;
	logic [INDEX_W-1:0] read_index;

	modport source (output valid, output req_type, output char_code, output read_index,
		input ready);
	modport sink (input valid, input req_type, input char_code, input read_index,
		output ready);
endinterface

// Result channel
interface ttw_res_if;
	import ttw_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [COL_OUT_W-1:0] cursor_column;
	logic [ROW_OUT_W-1:0] cursor_row;
	logic [POS_OUT_W-1:0] cursor_position;
	logic                 did_scroll;
	logic [CELL_W-1:0]    cell_value;

	modport source (output valid, output cursor_column, output cursor_row,
		output cursor_position, output did_scroll, output cell_value, input ready);
	modport sink (input valid, input cursor_column, input cursor_row,
		input cursor_position, input did_scroll, input cell_value, output ready);
endinterface

// Attribute register write channel
interface ttw_cfg_if;
	import ttw_pkg::*;

	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] text_attribute;

	modport source (output valid, output text_attribute, input ready);
	modport sink (input valid, input text_attribute, output ready);
endinterface

### rtl/ttw_cell_ram.sv
// ----------------------------------------------------------------------------
// Text terminal writer cell store
// Single-clock memory of character cells with one write port and one read
// port; the read data is registered.
// ----------------------------------------------------------------------------
module ttw_cell_ram #(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ttw_pkg::CELL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [ttw_pkg::CELL_W-1:0] rdata
);
	import ttw_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ttw_ctrl.sv
// ----------------------------------------------------------------------------
// Text terminal writer sequencer
// Takes one request at a time, updates the cursor position with a single
// adder, and runs the sweep engine that scrolls or clears the cell store one
// cell per cycle through the shared memory ports.
// ----------------------------------------------------------------------------
module ttw_ctrl #(
	parameter int SCREEN_COLUMNS = ttw_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = ttw_pkg::SCREEN_ROWS_DEF,
	localparam int PW = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ttw_req_if.sink                    req,
	input  logic [ttw_pkg::ATTR_W-1:0] attr,
	output logic                       res_valid,
	input  logic                       res_ready,
	output ttw_pkg::result_t           result,
	output logic                       ram_we,
	output logic [PW-1:0]              ram_waddr,
	output logic [ttw_pkg::CELL_W-1:0] ram_wdata,
	output logic                       ram_re,
	output logic [PW-1:0]              ram_raddr,
	input  logic [ttw_pkg::CELL_W-1:0] ram_rdata
);
	import ttw_pkg::*;

	localparam int CELLS     = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int CW        = $clog2(SCREEN_COLUMNS);
	localparam int RW        = $clog2(SCREEN_ROWS);
	localparam int COPY_END  = CELLS - SCREEN_COLUMNS;
	localparam int LAST_BASE = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [REQ_W-1:0]   type_q;
	logic [CHAR_W-1:0]  code_q;
	logic [INDEX_W-1:0] idx_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [PW-1:0]      pos_q;
	logic               scrolled_q;
	logic [CELL_W-1:0]  cell_q;
	logic [PW-1:0]      ptr_q;
	logic               copy_q;
	logic               valid_s1;
	logic               copy_s1;
	logic [PW-1:0]      addr_s1;

	logic [CELL_W-1:0]     blank;
	logic                  at_last_col;
	logic                  at_last_row;
	logic                  col_zero;
	logic                  is_newline;
	logic                  is_return;
	logic                  is_backspace;
	logic [PW-1:0]         col_ext;
	logic [PW-1:0]         op_b;
	logic [PW-1:0]         pos_sum;
	logic [PW+INDEX_W-1:0] idx_ext;
	logic                  idx_in_range;
	logic                  copy_now;
	logic [PW-1:0]         src_addr;
	logic                  exec_put;
	logic                  exec_write;
	logic [PW-1:0]         exec_addr;
	logic [CELL_W-1:0]     exec_data;
	logic [CW+COL_OUT_W-1:0] col_out_ext;
	logic [RW+ROW_OUT_W-1:0] row_out_ext;
	logic [PW+POS_OUT_W-1:0] pos_out_ext;

	assign req.ready = (state_q == S_IDLE);

	// Decode of the held request and the cursor
	assign blank        = {attr, BLANK_GLYPH};
	assign at_last_col  = (col_q == CW'(SCREEN_COLUMNS - 1));
	assign at_last_row  = (row_q == RW'(SCREEN_ROWS - 1));
	assign col_zero     = (col_q == '0);
	assign is_newline   = (code_q == CODE_NEWLINE);
	assign is_return    = (code_q == CODE_RETURN);
	assign is_backspace = (code_q == CODE_BACKSPACE);
	assign col_ext      = PW'(col_q);

	// Position adder: the one adder for all moves of the cursor position
	always_comb begin
		if (is_newline) begin
			op_b = PW'(SCREEN_COLUMNS) - col_ext;
		end else if (is_return) begin
			op_b = '0 - col_ext;
		end else if (is_backspace) begin
			op_b = '1;
		end else begin
			op_b = PW'(1);
		end
	end
	assign pos_sum = pos_q + op_b;

	// Range check of a read index
	assign idx_ext      = {{PW{1'b0}}, idx_q};
	assign idx_in_range = (idx_ext < (PW + INDEX_W)'(CELLS));

	// Sweep engine: a copy cell reads one row further down
	assign copy_now = copy_q && (ptr_q < PW'(COPY_END));
	assign src_addr = ptr_q + PW'(SCREEN_COLUMNS);

	// Cell writes issued by a put request
	assign exec_put   = (state_q == S_EXEC) && (type_q == REQ_PUT);
	assign exec_write = exec_put && !is_newline && !is_return && (!is_backspace || !col_zero);
	assign exec_addr  = is_backspace ? pos_sum : pos_q;
	assign exec_data  = is_backspace ? blank : {attr, code_q};

	// Memory ports; sweep writes and put writes never fall in the same cycle
	assign ram_we    = valid_s1 || exec_write;
	assign ram_waddr = valid_s1 ? addr_s1 : exec_addr;
	assign ram_wdata = valid_s1 ? (copy_s1 ? ram_rdata : blank) : exec_data;
	assign ram_re    = ((state_q == S_SWEEP) && copy_now) ||
		((state_q == S_EXEC) && (type_q == REQ_READ) && idx_in_range);
	assign ram_raddr = (state_q == S_SWEEP) ? src_addr : idx_ext[PW-1:0];

	// Result record
	assign col_out_ext = {{COL_OUT_W{1'b0}}, col_q};
	assign row_out_ext = {{ROW_OUT_W{1'b0}}, row_q};
	assign pos_out_ext = {{POS_OUT_W{1'b0}}, pos_q};
	assign res_valid   = (state_q == S_DONE);
	always_comb begin
		result.cursor_column   = col_out_ext[COL_OUT_W-1:0];
		result.cursor_row      = row_out_ext[ROW_OUT_W-1:0];
		result.cursor_position = pos_out_ext[POS_OUT_W-1:0];
		result.did_scroll      = scrolled_q;
		result.cell_value      = cell_q;
	end

	// Request capture, held for the whole request
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_q <= req.req_type;
			code_q <= req.char_code;
			idx_q  <= req.read_index;
		end
	end

	// Sequencer, cursor and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			pos_q      <= '0;
			scrolled_q <= 1'b0;
			cell_q     <= '0;
			ptr_q      <= '0;
			copy_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						scrolled_q <= 1'b0;
						cell_q     <= '0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (type_q)
						REQ_PUT: begin
							if (is_newline || (!is_return && !is_backspace && at_last_col)) begin
								// Step to the next row, scrolling below the last one
								col_q <= '0;
								if (at_last_row) begin
									pos_q      <= PW'(LAST_BASE);
									scrolled_q <= 1'b1;
									ptr_q      <= '0;
									copy_q     <= 1'b1;
									state_q    <= S_SWEEP;
								end else begin
									row_q <= row_q + RW'(1);
									pos_q <= pos_sum;
								end
							end else if (is_return) begin
								col_q <= '0;
								pos_q <= pos_sum;
							end else if (is_backspace) begin
								if (!col_zero) begin
									col_q <= col_q - CW'(1);
									pos_q <= pos_sum;
								end
							end else begin
								col_q <= col_q + CW'(1);
								pos_q <= pos_sum;
							end
						end
						REQ_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							pos_q   <= '0;
							ptr_q   <= '0;
							copy_q  <= 1'b0;
							state_q <= S_SWEEP;
						end
						REQ_READ: begin
							if (idx_in_range) begin
								state_q <= S_READ;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_READ: begin
					cell_q  <= ram_rdata;
					state_q <= S_DONE;
				end
				S_SWEEP: begin
					ptr_q <= ptr_q + PW'(1);
					if (ptr_q == PW'(CELLS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Sweep write stage, which writes in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_SWEEP);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		copy_s1 <= copy_now;
	end

endmodule

### rtl/text_terminal_writer_top.sv
// ----------------------------------------------------------------------------
// Text terminal writer
// Character-cell console engine: a store of attribute/glyph cells with a
// cursor, handling printable bytes, newline, carriage return, backspace,
// scrolling, clearing and single-cell reads.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Moves per transfer
//   req      in         req_type, char_code, read_index
//   res      out        cursor_column, cursor_row, cursor_position,
//                       did_scroll, cell_value
//   cfg      in         text_attribute (always ready)
//
// Requests are taken only while the sequencer is idle, one at a time. A clear,
// and a put that scrolls, sweep all COLUMNS*ROWS cells (2000 at 80x25): the
// sweep moves one cell per cycle through the single write port of the store.
// Reset homes the cursor and sets the attribute to 0x07; the cell store is
// undefined until the first clear. A stalled result sits in the output
// register while the next request is already being worked on.
//
module text_terminal_writer_top #(
	parameter int SCREEN_COLUMNS = ttw_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = ttw_pkg::SCREEN_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ttw_req_if.sink    req,
	ttw_res_if.source  res,
	ttw_cfg_if.sink    cfg
);
	import ttw_pkg::*;

`include "assert_macros.svh"

	localparam int PW = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);

	logic [ATTR_W-1:0] attr_q;
	logic              ctrl_res_valid;
	logic              ctrl_res_ready;
	result_t           ctrl_result;
	result_t           out_q;
	logic              out_valid_q;
	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [PW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Attribute register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg.valid) begin
			attr_q <= cfg.text_attribute;
		end
	end

	// Sequencer
	ttw_ctrl #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.attr      (attr_q),
		.res_valid (ctrl_res_valid),
		.res_ready (ctrl_res_ready),
		.result    (ctrl_result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Cell store
	ttw_cell_ram #(
		.DEPTH (SCREEN_COLUMNS * SCREEN_ROWS)
	) u_cell_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: takes a new result when empty or being emptied
	assign ctrl_res_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_res_valid && ctrl_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_res_valid && ctrl_res_ready) begin
			out_q <= ctrl_result;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.cursor_column   = out_q.cursor_column;
	assign res.cursor_row      = out_q.cursor_row;
	assign res.cursor_position = out_q.cursor_position;
	assign res.did_scroll      = out_q.did_scroll;
	assign res.cell_value      = out_q.cell_value;

	// The sequencer never offers a result while it is taking requests
	`TTW_ASSERT_NEVER(a_idle_without_result, req.ready && ctrl_res_valid)
	// A request transfer makes the block busy in the following cycle
	`TTW_ASSERT_NEXT(a_busy_after_request, req.valid && req.ready, !req.ready)
	// A scroll always leaves the cursor at the start of a row
	`TTW_ASSERT_IMPL(a_scroll_homes_column, res.valid && res.did_scroll, res.cursor_column == '0)

endmodule
